// ===== rtl/lzwe_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwe_pkg
// Types and constants shared by the LZW encoder modules.
// ----------------------------------------------------------------------------
package lzwe_pkg;

    localparam int DICT_ENTRIES_DEF = 4096;
    localparam int HASH_SLOTS_DEF   = 8192;

    localparam int CODE_W  = 12;
    localparam int BYTE_W  = 8;
    localparam int KEY_W   = CODE_W + BYTE_W;
    localparam int NFC_W   = 13;
    localparam int EPOCH_W = 8;

    localparam logic [NFC_W-1:0]   FIRST_FREE_CODE = 13'd256;
    localparam logic [CODE_W-1:0]  CODE_LIMIT_RST  = 12'd4095;
    localparam logic [31:0]        HASH_MULT       = 32'd2654435761;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic              last;
        logic [BYTE_W-1:0] data;
    } in_item_t;

    typedef struct packed {
        logic              last;
        logic [CODE_W-1:0] code;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_READ,
        ST_CMP,
        ST_LAST
    } eng_state_t;

endpackage

// ===== rtl/lzwe_fifo.sv =====
// ----------------------------------------------------------------------------
// lzwe_fifo
// Small synchronous queue with a stream handshake on both sides.
// ----------------------------------------------------------------------------
module lzwe_fifo #(
    parameter int Width = 9,
    parameter int Depth = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_valid,
    output logic                       wr_ready,
    input  logic [Width-1:0]           wr_data,
    output logic                       rd_valid,
    input  logic                       rd_ready,
    output logic [Width-1:0]           rd_data,
    output logic [$clog2(Depth):0]     level
);
    localparam int AW = $clog2(Depth);

    logic [Width-1:0] mem [Depth];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg, count_next;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != (AW+1)'(Depth));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];
    assign level    = count_reg;

    always_comb begin
        count_next = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/lzwe_engine.sv =====
// ----------------------------------------------------------------------------
// lzwe_engine
// Dictionary lookup sequencer: hashes (prefix, byte), probes the table
// linearly, emits codes and inserts new entries.
// ----------------------------------------------------------------------------
module lzwe_engine #(
    parameter int DictEntries = 4096,
    parameter int HashSlots   = 8192
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [lzwe_pkg::CODE_W-1:0]       code_limit,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lzwe_pkg::in_item_t                in_item,
    output logic                              out_push,
    output lzwe_pkg::out_item_t               out_item,
    input  logic [$clog2(lzwe_pkg::QUEUE_DEPTH):0] out_level
);
    import lzwe_pkg::*;

    // HashSlots must be a power of two, which this block does not enforce; the slot index is a mask of the hash.
    localparam int SW    = $clog2(HashSlots);
    localparam int ENT_W = EPOCH_W + KEY_W + CODE_W;
    localparam int LVL_W = $clog2(QUEUE_DEPTH) + 1;

    logic [ENT_W-1:0] mem [HashSlots];
    logic [ENT_W-1:0] rd_reg;

    eng_state_t          state_reg, state_next;
    in_item_t            item_reg, item_next;
    logic [CODE_W-1:0]   prefix_reg, prefix_next;
    logic                held_reg, held_next;
    logic [NFC_W-1:0]    nfc_reg, nfc_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic [SW-1:0]       cnt_reg, cnt_next;
    logic [SW-1:0]       clr_reg, clr_next;
    logic [31:0]         prod_reg, prod_next;

    logic [KEY_W-1:0]    key;
    logic [31:0]         fold;
    logic [EPOCH_W-1:0]  rd_tag;
    logic [KEY_W-1:0]    rd_key;
    logic [CODE_W-1:0]   rd_code;
    logic                occupied, hit, give_up, can_add, room, pop, end_msg, wrap;
    logic                we;
    logic [SW-1:0]       waddr;
    logic [ENT_W-1:0]    wdata;

    assign key      = {prefix_reg, item_reg.data};
    assign fold     = prod_reg ^ (prod_reg >> 15);
    assign rd_tag   = rd_reg[ENT_W-1 -: EPOCH_W];
    assign rd_key   = rd_reg[CODE_W +: KEY_W];
    assign rd_code  = rd_reg[CODE_W-1:0];
    assign occupied = (rd_tag == epoch_reg);
    assign hit      = occupied && (rd_key == key);
    assign give_up  = occupied && !hit && (&cnt_reg);
    assign can_add  = !occupied && (nfc_reg[CODE_W-1:0] <= code_limit) && !nfc_reg[NFC_W-1]
                      && (32'(nfc_reg) < 32'(DictEntries));
    assign room     = (out_level <= LVL_W'(QUEUE_DEPTH - 2));
    assign wrap     = (&epoch_reg);

    assign in_ready = (state_reg == ST_IDLE) && room;
    assign pop      = in_ready && in_valid;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (&clr_reg) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (pop) begin
                    if (!held_reg) begin
                        if (in_item.last && wrap) state_next = ST_CLEAR;
                    end else begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH:  state_next = ST_PROBE;
            ST_PROBE: state_next = ST_READ;
            ST_READ:  state_next = ST_CMP;
            ST_CMP: begin
                if (hit) begin
                    state_next = (item_reg.last && wrap) ? ST_CLEAR : ST_IDLE;
                end else if (!occupied || give_up) begin
                    state_next = item_reg.last ? ST_LAST : ST_IDLE;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_LAST: state_next = wrap ? ST_CLEAR : ST_IDLE;
            default: state_next = ST_CLEAR;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        item_next   = item_reg;
        prefix_next = prefix_reg;
        held_next   = held_reg;
        nfc_next    = nfc_reg;
        slot_next   = slot_reg;
        cnt_next    = cnt_reg;
        clr_next    = clr_reg;
        prod_next   = prod_reg;
        out_push    = 1'b0;
        out_item    = '{last: 1'b0, code: prefix_reg};
        we          = 1'b0;
        waddr       = slot_reg;
        wdata       = {epoch_reg, key, nfc_reg[CODE_W-1:0]};
        end_msg     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE: begin
                if (pop) begin
                    item_next = in_item;
                    if (!held_reg) begin
                        prefix_next = {{(CODE_W-BYTE_W){1'b0}}, in_item.data};
                        held_next   = 1'b1;
                        if (in_item.last) begin
                            out_push = 1'b1;
                            out_item = '{last: 1'b1,
                                         code: {{(CODE_W-BYTE_W){1'b0}}, in_item.data}};
                            end_msg  = 1'b1;
                        end
                    end
                end
            end
            ST_HASH: begin
                prod_next = 32'({{(32-KEY_W){1'b0}}, key} * HASH_MULT);
            end
            ST_PROBE: begin
                slot_next = fold[SW-1:0];
                cnt_next  = '0;
            end
            ST_READ: begin
            end
            ST_CMP: begin
                if (hit) begin
                    prefix_next = rd_code;
                    if (item_reg.last) begin
                        out_push = 1'b1;
                        out_item = '{last: 1'b1, code: rd_code};
                        end_msg  = 1'b1;
                    end
                end else if (!occupied || give_up) begin
                    out_push = 1'b1;
                    if (can_add) begin
                        we       = 1'b1;
                        nfc_next = nfc_reg + 1'b1;
                    end
                    prefix_next = {{(CODE_W-BYTE_W){1'b0}}, item_reg.data};
                end else begin
                    slot_next = slot_reg + 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            ST_LAST: begin
                out_push = 1'b1;
                out_item = '{last: 1'b1, code: prefix_reg};
                end_msg  = 1'b1;
            end
            default: begin
            end
        endcase
        // Ending a message retires the epoch; table tags of older epochs read as empty.
        epoch_next = epoch_reg;
        if (end_msg) begin
            held_next   = 1'b0;
            prefix_next = '0;
            nfc_next    = FIRST_FREE_CODE;
            epoch_next  = wrap ? EPOCH_W'(1) : epoch_reg + 1'b1;
            clr_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            held_reg   <= 1'b0;
            prefix_reg <= '0;
            nfc_reg    <= FIRST_FREE_CODE;
            epoch_reg  <= EPOCH_W'(1);
            clr_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            held_reg   <= held_next;
            prefix_reg <= prefix_next;
            nfc_reg    <= nfc_next;
            epoch_reg  <= epoch_next;
            clr_reg    <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        slot_reg <= slot_next;
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[slot_reg];
    end

endmodule

// ===== rtl/lzw_encoder_core.sv =====
// ----------------------------------------------------------------------------
// lzw_encoder_core
// Greedy LZW encoder with 12-bit codes and a hashed dictionary.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  s_axis   | in        | tdata[7:0] = in_byte, tlast = in_last
//  m_axis   | out       | tdata[11:0] = out_code, tlast = out_last
//  cfg      | in        | cfg_wdata = code_limit
//
// The engine takes a message's first byte in its idle state. Later bytes pass
// the hash, probe, read and compare states, and read and compare again per
// extra probe of the linear-probe table; a final byte that misses adds a last
// state. Bytes wait in a four-entry input queue, codes in a four-entry output
// queue; the engine takes a byte only while the output queue has two free
// entries. After reset, and after every 255 messages, a clearing pass writes
// all HASH_SLOTS table entries, one per cycle, while the engine takes no byte.
// ----------------------------------------------------------------------------
module lzw_encoder_core #(
    parameter int DictEntries = lzwe_pkg::DICT_ENTRIES_DEF,
    parameter int HashSlots   = lzwe_pkg::HASH_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] out_code, [15:12] zero
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata
);
    import lzwe_pkg::*;

    localparam int LVL_W = $clog2(QUEUE_DEPTH) + 1;

    logic [CODE_W-1:0] code_limit_reg;
    in_item_t          s_item, q_item;
    out_item_t         e_item, m_item;
    logic              q_valid, q_ready, e_push;
    logic [LVL_W-1:0]  out_level;

    assign s_item = '{last: s_tlast, data: s_tdata};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_limit_reg <= CODE_LIMIT_RST;
        end else if (cfg_we) begin
            code_limit_reg <= cfg_wdata;
        end
    end

    lzwe_fifo #(.Width($bits(in_item_t)), .Depth(QUEUE_DEPTH)) u_in_q (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_data  (s_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_item),
        .level    ()
    );

    lzwe_engine #(.DictEntries(DictEntries), .HashSlots(HashSlots)) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .code_limit (code_limit_reg),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .out_push   (e_push),
        .out_item   (e_item),
        .out_level  (out_level)
    );

    // Bytes are taken only with two entries free, so no push is refused.
    lzwe_fifo #(.Width($bits(out_item_t)), .Depth(QUEUE_DEPTH)) u_out_q (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (e_push),
        .wr_ready (),
        .wr_data  (e_item),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (m_item),
        .level    (out_level)
    );

    assign m_tdata = {4'b0000, m_item.code};
    assign m_tlast = m_item.last;

endmodule
